// ===== hdl/pfx_pkg.sv =====
// ----------------------------------------------------------------------------
// pfx_pkg: shared definitions for the postfix expression evaluator
// Holds the stack and data sizes, the character codes, the arithmetic
// operation codes and the request and status bundles of the shared ALU.
// ----------------------------------------------------------------------------
package pfx_pkg;

  // Operand stack geometry and arithmetic width.
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W      = $clog2(DATA_WIDTH);

  // Result value width on the output stream.
  localparam int VALUE_W = 32;

  // Character codes of the expression alphabet.
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_MINUS = 8'h2d;
  localparam logic [7:0] SYM_PLUS  = 8'h2b;
  localparam logic [7:0] SYM_TIMES = 8'h2a;
  localparam logic [7:0] SYM_SLASH = 8'h2f;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Status from the arithmetic unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic div0;
  } alu_status_t;

endpackage

// ===== hdl/postfix_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit: stack-based postfix expression evaluator
// Evaluates one postfix expression per frame and returns its value and flags.
// ----------------------------------------------------------------------------
// Feed one ASCII character per transaction on the slave stream, tlast on the
// final character. Digits push their value, the operators - + * / pop two
// operands and push the result (wrapping arithmetic, division truncates toward
// zero, a zero divisor gives 0). Other characters are ignored. After the final
// character the top of the stack (-1 if empty) goes out on the master stream
// with sticky underflow, overflow and divide-by-zero flags, and the stack is
// cleared. One character is taken at a time: the next is accepted only once
// the previous one is done. Multiply and divide run bit-serially in the shared
// ALU, and after the final character come the last pop and the result handoff.
// The stack lives in a RAM with registered read, so every pop has a read state
// and a latch state.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit
  import pfx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] symbol
  input  logic         s_tlast,   // last character of the expression
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // [31:0] value
  output logic [2:0]   m_tuser    // [0] underflow, [1] overflow, [2] divide_by_zero
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_RD_R  = 10'b0000000100,
    S_LAT_R = 10'b0000001000,
    S_RD_L  = 10'b0000010000,
    S_LAT_L = 10'b0000100000,
    S_WAIT  = 10'b0001000000,
    S_RD_F  = 10'b0010000000,
    S_LAT_F = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } seq_state_t;

  seq_state_t            state;
  logic [7:0]            sym;
  logic                  last;
  logic [COUNT_W-1:0]    count;
  logic                  flag_under;
  logic                  flag_over;
  logic                  flag_div0;
  logic                  pop_empty;
  logic [DATA_WIDTH-1:0] rhs;

  logic                  is_digit;
  logic                  is_op;
  logic                  full;
  logic [COUNT_W-1:0]    count_dec;
  logic [DATA_WIDTH-1:0] pop_data;
  alu_op_t               op;
  alu_req_t              alu_req;
  alu_status_t           alu_status;
  logic [DATA_WIDTH-1:0] alu_result;

  logic                  ram_we;
  logic [STACK_AW-1:0]   ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Character decode.
  assign is_digit = (sym >= SYM_ZERO) && (sym <= SYM_NINE);
  assign is_op    = (sym == SYM_MINUS) || (sym == SYM_PLUS) ||
                    (sym == SYM_TIMES) || (sym == SYM_SLASH);

  always_comb begin
    case (sym)
      SYM_MINUS: op = OP_SUB;
      SYM_PLUS:  op = OP_ADD;
      SYM_TIMES: op = OP_MUL;
      default:   op = OP_DIV;
    endcase
  end

  assign full      = (count == COUNT_W'(STACK_DEPTH));
  assign count_dec = count - 1'b1;
  assign pop_data  = pop_empty ? '1 : ram_rdata;
  assign s_tready  = (state == S_IDLE);

  // Stack write port: digits in decode, operator results when the ALU is done.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[STACK_AW-1:0];
    ram_wdata = alu_result;
    if (state == S_EXEC && is_digit && !full) begin
      ram_we    = 1'b1;
      ram_wdata = DATA_WIDTH'(sym[3:0]);
    end else if (state == S_WAIT && alu_status.done) begin
      ram_we = 1'b1;
    end
  end

  // Operands go to the ALU as soon as the left one comes out of the RAM.
  assign alu_req.start = (state == S_LAT_L);
  assign alu_req.op    = op;

  pfx_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (count_dec[STACK_AW-1:0]),
    .rdata (ram_rdata)
  );

  pfx_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (pop_data),
    .b      (rhs),
    .status (alu_status),
    .result (alu_result)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      flag_under <= 1'b0;
      flag_over  <= 1'b0;
      flag_div0  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // The emit state handles the output register itself.
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sym   <= s_tdata;
            last  <= s_tlast;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_op) begin
            state <= S_RD_R;
          end else begin
            if (is_digit) begin
              if (full) begin
                flag_over <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
            end
            state <= last ? S_RD_F : S_IDLE;
          end
        end
        S_RD_R, S_RD_L, S_RD_F: begin
          // Pop: the RAM read of the top entry is issued this cycle.
          if (count == '0) begin
            flag_under <= 1'b1;
            pop_empty  <= 1'b1;
          end else begin
            count     <= count_dec;
            pop_empty <= 1'b0;
          end
          case (state)
            S_RD_R:  state <= S_LAT_R;
            S_RD_L:  state <= S_LAT_L;
            default: state <= S_LAT_F;
          endcase
        end
        S_LAT_R: begin
          rhs   <= pop_data;
          state <= S_RD_L;
        end
        S_LAT_L: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_status.done) begin
            count <= count + 1'b1;
            if (alu_status.div0) begin
              flag_div0 <= 1'b1;
            end
            state <= last ? S_RD_F : S_IDLE;
          end
        end
        S_LAT_F: begin
          rhs   <= pop_data;
          state <= S_EMIT;
        end
        S_EMIT: begin
          // Hand the result over once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= VALUE_W'(rhs);
            m_tuser    <= {flag_div0, flag_over, flag_under};
            count      <= '0;
            flag_under <= 1'b0;
            flag_over  <= 1'b0;
            flag_div0  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/pfx_ram.sv =====
// ----------------------------------------------------------------------------
// pfx_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pfx_alu.sv =====
// ----------------------------------------------------------------------------
// pfx_alu: shared iterative arithmetic unit
// Add and subtract finish in one step; multiply is shift-and-add and divide
// is restoring division on magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module pfx_alu
  import pfx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  alu_req_t              req,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output alu_status_t           status,
  output logic [DATA_WIDTH-1:0] result
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_DONE = 4'b1000
  } alu_state_t;

  alu_state_t            state;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] opnd;
  logic [DATA_WIDTH-1:0] shreg;
  logic [STEP_W-1:0]     step;
  logic                  negate;
  logic                  div0;

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] mul_next;
  logic [DATA_WIDTH-1:0] quot_next;

  // Operand magnitudes for division.
  assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

  // One step of each iteration.
  assign mul_next  = acc + (shreg[0] ? opnd : '0);
  assign rem_sh    = {acc, shreg[DATA_WIDTH-1]};
  assign diff      = rem_sh - {1'b0, opnd};
  assign quot_next = {shreg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};

  assign status.done = (state == A_DONE);
  assign status.div0 = div0;

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      div0  <= 1'b0;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.start) begin
            div0 <= 1'b0;
            case (req.op)
              OP_ADD: begin
                result <= a + b;
                state  <= A_DONE;
              end
              OP_SUB: begin
                result <= a - b;
                state  <= A_DONE;
              end
              OP_MUL: begin
                acc   <= '0;
                opnd  <= a;
                shreg <= b;
                step  <= STEP_W'(DATA_WIDTH - 1);
                state <= A_MUL;
              end
              default: begin
                if (b == '0) begin
                  result <= '0;
                  div0   <= 1'b1;
                  state  <= A_DONE;
                end else begin
                  acc    <= '0;
                  opnd   <= mag_b;
                  shreg  <= mag_a;
                  negate <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                  step   <= STEP_W'(DATA_WIDTH - 1);
                  state  <= A_DIV;
                end
              end
            endcase
          end
        end
        A_MUL: begin
          acc   <= mul_next;
          opnd  <= {opnd[DATA_WIDTH-2:0], 1'b0};
          shreg <= {1'b0, shreg[DATA_WIDTH-1:1]};
          step  <= step - 1'b1;
          if (step == '0) begin
            result <= mul_next;
            state  <= A_DONE;
          end
        end
        A_DIV: begin
          // Keep the remainder only when the trial subtraction holds.
          if (!diff[DATA_WIDTH]) begin
            acc <= diff[DATA_WIDTH-1:0];
          end else begin
            acc <= rem_sh[DATA_WIDTH-1:0];
          end
          shreg <= quot_next;
          step  <= step - 1'b1;
          if (step == '0) begin
            result <= negate ? (~quot_next + 1'b1) : quot_next;
            state  <= A_DONE;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule
